>>> rtl/cmbc_pkg.sv
// Shared types and constants for the color marker band centroid unit.
`timescale 1ns / 1ps

package cmbc_pkg;

   // Frame geometry limits.
   localparam int unsigned MAX_COLS = 2048;
   localparam int unsigned MAX_ROWS = 2048;

   // Field widths.
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned POS_W   = 11;
   localparam int unsigned ROWS_W  = 12;
   localparam int unsigned LIM_W   = 13;  // wide enough for MAX_COLS and MAX_ROWS
   localparam int unsigned COUNT_W = 19;
   localparam int unsigned SUM_W   = 30;

   // Divider geometry.
   localparam int unsigned DIV_STEPS = SUM_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Band bounds: floor(k*rows/10) = (rows * k * ceil(2^16/10)) >> 16,
   // exact for k*rows below 16384.
   localparam int unsigned MULT_W   = 16;
   localparam int unsigned PROD_W   = ROWS_W + MULT_W;
   localparam logic [MULT_W-1:0] BAND_LO_MULT = MULT_W'(6 * 6554);
   localparam logic [MULT_W-1:0] BAND_HI_MULT = MULT_W'(7 * 6554);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register reset values.
   localparam logic [ROWS_W-1:0]  FRAME_ROWS_RST = ROWS_W'(480);
   localparam logic [COLOR_W-1:0] BLUE_MAX_RST   = COLOR_W'(200);
   localparam logic [COLOR_W-1:0] GREEN_MIN_RST  = COLOR_W'(170);
   localparam logic [COLOR_W-1:0] RED_MIN_RST    = COLOR_W'(170);

   // Configuration port.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = ROWS_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_ROWS = 2'd0,
      CSR_BLUE_MAX   = 2'd1,
      CSR_GREEN_MIN  = 2'd2,
      CSR_RED_MIN    = 2'd3
   } csr_index_type;

   // Stream payloads.
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 48;

   // Divider control and status between the sequencer and the divider.
   typedef struct packed {
      logic                 start;
      logic [SUM_W-1:0]     dividend;
      logic [COUNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [POS_W-1:0]     quotient;
   } div_rsp_type;

endpackage

>>> rtl/cmbc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both centroid axes.
`timescale 1ns / 1ps

module cmbc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cmbc_pkg::div_req_type div_req,
   output cmbc_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [cmbc_pkg::DIV_CNT_W-1:0]  step_ff, step_in;
   logic [cmbc_pkg::COUNT_W:0]      rem_ff, rem_in;
   logic [cmbc_pkg::SUM_W-1:0]      quot_ff, quot_in;
   logic [cmbc_pkg::COUNT_W-1:0]    dvsr_ff, dvsr_in;

   logic [cmbc_pkg::COUNT_W:0]      rem_shift;
   logic [cmbc_pkg::COUNT_W:0]      rem_diff;

   // quot_ff holds the unshifted dividend bits at the top and the quotient
   // bits at the bottom as the division goes on.
   always_comb begin
      rem_shift = {rem_ff[cmbc_pkg::COUNT_W-1:0], quot_ff[cmbc_pkg::SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, dvsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvsr_ff}) begin
            rem_in  = rem_diff;
            quot_in = {quot_ff[cmbc_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            quot_in = {quot_ff[cmbc_pkg::SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == cmbc_pkg::DIV_CNT_W'(cmbc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff[cmbc_pkg::POS_W-1:0];

endmodule

>>> rtl/color_marker_band_centroid_unit.sv
// Top level of the color marker band centroid unit: sequencer, accumulators, output register.
`timescale 1ns / 1ps

//  Channel | Direction | Ports                                  | Contents
//  --------+-----------+----------------------------------------+------------------------------
//  req     | in        | req_tvalid/tready/tdata/tlast          | one pixel, tlast = frame end
//  rsp     | out       | rsp_tvalid/tready/tdata                | centroid and match count
//  csr     | in        | csr_wen/csr_index/csr_wdata            | frame_rows and color limits
//
// A pixel that does not end a frame passes through the accept cycle in ST_IDLE, then
// ST_BAND_LO and ST_BAND_HI, in which the shared multiplier works out the lower and upper
// band rows from frame_rows, and then ST_ACCUM, which tests the pixel and updates the sums.
// A pixel that ends a frame, when anything matched, then runs one pass of the bit-serial
// divider for each axis, in ST_DIV_X and ST_DIV_Y, before ST_EMIT loads the output register.
// With no match only that load follows. Reset is synchronous and active high; it restores
// the register reset values and clears the sums. req_tready is low while a pixel is in work.
// A stalled rsp side holds the finished result in the output register, and the sequencer
// waits for it only when the next result is ready to be loaded.

module color_marker_band_centroid_unit (
   input  logic                            clock,
   input  logic                            reset,

   // Pixel transactions.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata from bit 0: blue[7:0], green[15:8], red[23:16], col_pos[34:24],
   // row_pos[45:35], zero fill[47:46].
   input  logic [cmbc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,   // frame_end

   // Result transactions.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata from bit 0: centroid_x[10:0], centroid_y[21:11], match_total[40:22],
   // zero fill[47:41].
   output logic [cmbc_pkg::RSP_DATA_W-1:0] rsp_tdata,

   // Configuration writes.
   input  logic                            csr_wen,
   input  logic [cmbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cmbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAND_LO,
      ST_BAND_HI,
      ST_ACCUM,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [cmbc_pkg::ROWS_W-1:0]  frame_rows_ff;
   logic [cmbc_pkg::COLOR_W-1:0] blue_max_ff;
   logic [cmbc_pkg::COLOR_W-1:0] green_min_ff;
   logic [cmbc_pkg::COLOR_W-1:0] red_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= cmbc_pkg::FRAME_ROWS_RST;
         blue_max_ff   <= cmbc_pkg::BLUE_MAX_RST;
         green_min_ff  <= cmbc_pkg::GREEN_MIN_RST;
         red_min_ff    <= cmbc_pkg::RED_MIN_RST;
      end else if (csr_wen) begin
         unique case (cmbc_pkg::csr_index_type'(csr_index))
            cmbc_pkg::CSR_FRAME_ROWS: frame_rows_ff <= csr_wdata;
            cmbc_pkg::CSR_BLUE_MAX:   blue_max_ff   <= csr_wdata[cmbc_pkg::COLOR_W-1:0];
            cmbc_pkg::CSR_GREEN_MIN:  green_min_ff  <= csr_wdata[cmbc_pkg::COLOR_W-1:0];
            cmbc_pkg::CSR_RED_MIN:    red_min_ff    <= csr_wdata[cmbc_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state, captured pixel, band bounds, sums and output register.
   state_type                    state_ff, state_in;
   logic [cmbc_pkg::COLOR_W-1:0] blue_ff, green_ff, red_ff;
   logic [cmbc_pkg::POS_W-1:0]   col_ff, row_ff;
   logic                         last_ff;
   logic [cmbc_pkg::ROWS_W-1:0]  band_lo_ff, band_lo_in;
   logic [cmbc_pkg::ROWS_W-1:0]  band_hi_ff, band_hi_in;
   logic [cmbc_pkg::COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic [cmbc_pkg::SUM_W-1:0]   col_sum_ff, col_sum_in;
   logic [cmbc_pkg::SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic [cmbc_pkg::POS_W-1:0]   cx_ff, cx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cmbc_pkg::POS_W-1:0]   rsp_cx_ff, rsp_cx_in;
   logic [cmbc_pkg::POS_W-1:0]   rsp_cy_ff, rsp_cy_in;
   logic [cmbc_pkg::COUNT_W-1:0] rsp_total_ff, rsp_total_in;

   logic req_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Shared band multiplier: rows clamped to MAX_ROWS, times the scaled factor.
   logic [cmbc_pkg::ROWS_W-1:0] rows_clamped;
   logic [cmbc_pkg::MULT_W-1:0] band_mult;
   logic [cmbc_pkg::PROD_W-1:0] band_prod;

   always_comb begin
      if (cmbc_pkg::LIM_W'(frame_rows_ff) > cmbc_pkg::LIM_W'(cmbc_pkg::MAX_ROWS)) begin
         rows_clamped = cmbc_pkg::ROWS_W'(cmbc_pkg::MAX_ROWS);
      end else begin
         rows_clamped = frame_rows_ff;
      end
      band_mult = (state_ff == ST_BAND_HI) ? cmbc_pkg::BAND_HI_MULT : cmbc_pkg::BAND_LO_MULT;
      band_prod = cmbc_pkg::PROD_W'(rows_clamped) * cmbc_pkg::PROD_W'(band_mult);
   end

   // Pixel test.
   logic in_frame, in_band, color_ok, take_hit;
   always_comb begin
      in_frame = (cmbc_pkg::LIM_W'(col_ff) < cmbc_pkg::LIM_W'(cmbc_pkg::MAX_COLS)) &&
                 (cmbc_pkg::LIM_W'(row_ff) < cmbc_pkg::LIM_W'(cmbc_pkg::MAX_ROWS));
      in_band  = (cmbc_pkg::ROWS_W'(row_ff) >= band_lo_ff) &&
                 (cmbc_pkg::ROWS_W'(row_ff) < band_hi_ff);
      color_ok = (blue_ff <= blue_max_ff) && (green_ff >= green_min_ff) &&
                 (red_ff >= red_min_ff);
      take_hit = in_frame && in_band && color_ok && (hit_count_ff != cmbc_pkg::COUNT_MAX);
   end

   // Divider hookup.
   cmbc_pkg::div_req_type div_req;
   cmbc_pkg::div_rsp_type div_rsp;

   cmbc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      band_lo_in   = band_lo_ff;
      band_hi_in   = band_hi_ff;
      hit_count_in = hit_count_ff;
      col_sum_in   = col_sum_ff;
      row_sum_in   = row_sum_ff;
      cx_in        = cx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_total_in = rsp_total_ff;
      div_req.start    = 1'b0;
      div_req.dividend = col_sum_ff;
      div_req.divisor  = hit_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_BAND_LO;
            end
         end
         ST_BAND_LO: begin
            band_lo_in = band_prod[cmbc_pkg::PROD_W-1:cmbc_pkg::MULT_W];
            state_in   = ST_BAND_HI;
         end
         ST_BAND_HI: begin
            band_hi_in = band_prod[cmbc_pkg::PROD_W-1:cmbc_pkg::MULT_W];
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (take_hit) begin
               hit_count_in = hit_count_ff + 1'b1;
               col_sum_in   = col_sum_ff + cmbc_pkg::SUM_W'(col_ff);
               row_sum_in   = row_sum_ff + cmbc_pkg::SUM_W'(row_ff);
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (hit_count_in == '0) begin
               cx_in    = '0;
               state_in = ST_EMIT;
            end else begin
               // The divider latches the sums as they stand after this pixel.
               div_req.start    = 1'b1;
               div_req.dividend = col_sum_in;
               div_req.divisor  = hit_count_in;
               state_in         = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_rsp.done) begin
               cx_in            = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = row_sum_ff;
               div_req.divisor  = hit_count_ff;
               state_in         = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cx_in    = cx_ff;
               rsp_cy_in    = (hit_count_ff == '0) ? '0 : div_rsp.quotient;
               rsp_total_in = hit_count_ff;
               hit_count_in = '0;
               col_sum_in   = '0;
               row_sum_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_count_ff <= '0;
         col_sum_ff   <= '0;
         row_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_count_ff <= hit_count_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         blue_ff  <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         red_ff   <= req_tdata[23:16];
         col_ff   <= req_tdata[34:24];
         row_ff   <= req_tdata[45:35];
         last_ff  <= req_tlast;
      end
      band_lo_ff   <= band_lo_in;
      band_hi_ff   <= band_hi_in;
      cx_ff        <= cx_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_total_ff, rsp_cy_ff, rsp_cx_ff};

endmodule

>>> sim/cmbc_checker.sv
// Checker for the color marker band centroid unit: tracks pixels and compares centroid results.
`timescale 1ns / 1ps

module cmbc_checker
   import cmbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatches,
   output int unsigned            centroids_pending,
   output int unsigned            centroids_checked,
   output int unsigned            frames_with_hits
);

   // Pixel fields as they sit in req_tdata, lowest field last.
   typedef struct packed {
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   // Result fields as they sit in rsp_tdata, lowest field last.
   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic [POS_W-1:0]   y;
      logic [POS_W-1:0]   x;
   } centroid_type;

   logic [ROWS_W-1:0]  lim_rows;
   logic [COLOR_W-1:0] lim_blue;
   logic [COLOR_W-1:0] lim_green;
   logic [COLOR_W-1:0] lim_red;

   logic [COUNT_W-1:0] hits;
   logic [31:0]        col_total;
   logic [31:0]        row_total;

   centroid_type pending_centroids[$];
   int unsigned  bad_fields = 0;
   int unsigned  checked = 0;
   int unsigned  busy_frames = 0;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (bad_fields < 40)
         $display("MISMATCH at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
      bad_fields++;
   endtask

   // Adds a matching pixel to the running sums and closes the frame on its last pixel.
   task automatic fold_pixel(input pixel_type px, input logic last);
      int unsigned  rows;
      int unsigned  band_lo;
      int unsigned  band_hi;
      centroid_type c;
      rows    = (lim_rows > MAX_ROWS) ? MAX_ROWS : lim_rows;
      band_lo = (6 * rows) / 10;
      band_hi = (7 * rows) / 10;
      if (px.col < MAX_COLS && px.row < MAX_ROWS && px.row >= band_lo && px.row < band_hi &&
          px.blue <= lim_blue && px.green >= lim_green && px.red >= lim_red &&
          hits != COUNT_MAX) begin
         hits      = hits + 1'b1;
         col_total = col_total + px.col;
         row_total = row_total + px.row;
      end
      if (last) begin
         c.total = hits;
         c.x     = '0;
         c.y     = '0;
         if (hits != 0) begin
            c.x = POS_W'(col_total / 32'(hits));
            c.y = POS_W'(row_total / 32'(hits));
         end
         pending_centroids.insert(pending_centroids.size(), c);
         hits      = '0;
         col_total = '0;
         row_total = '0;
      end
   endtask

   task automatic check_centroid(input logic [RSP_DATA_W-1:0] data);
      centroid_type got;
      centroid_type want;
      got = data[$bits(centroid_type)-1:0];
      if (pending_centroids.size() == 0) begin
         report_mismatch("match_total of a result with no frame behind it", got.total, 0);
         return;
      end
      want = pending_centroids.pop_front();
      if (got.x != want.x)         report_mismatch("centroid_x", got.x, want.x);
      if (got.y != want.y)         report_mismatch("centroid_y", got.y, want.y);
      if (got.total != want.total) report_mismatch("match_total", got.total, want.total);
      checked++;
      if (want.total != 0) busy_frames++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lim_rows  = FRAME_ROWS_RST;
         lim_blue  = BLUE_MAX_RST;
         lim_green = GREEN_MIN_RST;
         lim_red   = RED_MIN_RST;
         hits      = '0;
         col_total = '0;
         row_total = '0;
         pending_centroids.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_ROWS: lim_rows  = csr_wdata[ROWS_W-1:0];
               CSR_BLUE_MAX:   lim_blue  = csr_wdata[COLOR_W-1:0];
               CSR_GREEN_MIN:  lim_green = csr_wdata[COLOR_W-1:0];
               CSR_RED_MIN:    lim_red   = csr_wdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         // A result leaving now can only belong to a frame closed earlier.
         if (rsp_tvalid && rsp_tready)
            check_centroid(rsp_tdata);
         if (req_tvalid && req_tready)
            fold_pixel(req_tdata[$bits(pixel_type)-1:0], req_tlast);
      end
      mismatches        <= bad_fields;
      centroids_pending <= pending_centroids.size();
      centroids_checked <= checked;
      frames_with_hits  <= busy_frames;
   end

endmodule

>>> sim/tb.sv
// Testbench top for the color marker band centroid unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
   import cmbc_pkg::*;

   // Random pixels to send after the directed frames.
   localparam int unsigned RANDOM_PIXELS = 1600;
   // Cycles the receiver stays stalled when a long hold-off is asked for.
   localparam int unsigned LONG_HOLD     = 600;
   // Cycles allowed after the last result for a busy pixel pipeline to settle.
   localparam int unsigned SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatches;
   int unsigned centroids_pending;
   int unsigned centroids_checked;
   int unsigned frames_with_hits;

   // The current register contents as this side wrote them; used only to aim pixels at the band
   // and at the color limits, never to work out results.
   int unsigned cur_rows  = FRAME_ROWS_RST;
   int unsigned cur_bmax  = BLUE_MAX_RST;
   int unsigned cur_gmin  = GREEN_MIN_RST;
   int unsigned cur_rmin  = RED_MIN_RST;

   int unsigned pixels_sent   = 0;
   int unsigned frames_sent   = 0;
   int unsigned settings_used = 0;

   // Sender pacing: a burst counter and a switch that turns the gaps off for a whole phase.
   int unsigned burst_left    = 0;
   logic        sender_steady = 1'b0;

   // Long receiver hold-offs are requested by bumping hold_asked; the receiver process
   // bumps hold_done when it has served one.
   int unsigned hold_asked = 0;
   int unsigned hold_done  = 0;

   color_marker_band_centroid_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cmbc_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .centroids_pending (centroids_pending),
      .centroids_checked (centroids_checked),
      .frames_with_hits  (frames_with_hits)
   );

   // A 20 ns clock, low for the first half period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Offers one pixel transaction and returns once it has been accepted. Before the first
   // pixel of each burst the sender may sit idle for a random gap, so gaps land on every
   // step of the unit's pixel work and on its divider passes.
   task automatic send_px(input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
                          input logic [COLOR_W-1:0] r, input logic [POS_W-1:0] col,
                          input logic [POS_W-1:0] row, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!sender_steady) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, row, col, r, g, b};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (last) frames_sent++;
   endtask

   // Drops valid and waits until every frame result has come back, then lets the unit settle
   // in case a pixel without a result is still in work.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (centroids_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers once the unit is idle. The color registers get junk in the
   // bits above their width, which the unit must drop.
   task automatic program_regs(input int unsigned rows, input int unsigned bmax,
                               input int unsigned gmin, input int unsigned rmin);
      logic [CSR_DATA_W-1:0] value [4];
      csr_index_type         idx;
      drain_results();
      value[CSR_FRAME_ROWS] = CSR_DATA_W'(rows);
      value[CSR_BLUE_MAX]   = {4'($urandom_range(0, 15)), 8'(bmax)};
      value[CSR_GREEN_MIN]  = {4'($urandom_range(0, 15)), 8'(gmin)};
      value[CSR_RED_MIN]    = {4'($urandom_range(0, 15)), 8'(rmin)};
      idx = idx.first();
      repeat (4) begin
         csr_wen   <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value[idx];
         @(posedge clock);
         idx = idx.next();
      end
      csr_wen  <= 1'b0;
      cur_rows  = rows;
      cur_bmax  = bmax;
      cur_gmin  = gmin;
      cur_rmin  = rmin;
      settings_used++;
   endtask

   // Sends one frame of n random pixels, the last one carrying the frame-end flag. Most rows
   // land inside the band and, picked apart from them, most colors pass; some rows sit on the band
   // edges and some colors sit on or just past a limit, and the rest are random.
   task automatic send_frame(input int unsigned n);
      int unsigned rows;
      int unsigned band_lo;
      int unsigned band_hi;
      int unsigned pick;
      logic [COLOR_W-1:0] b, g, r;
      logic [POS_W-1:0]   col, row;
      rows    = (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
      band_lo = (6 * rows) / 10;
      band_hi = (7 * rows) / 10;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && band_hi > band_lo)
            row = POS_W'($urandom_range(band_lo, band_hi - 1));
         else if (pick < 70) begin
            case ($urandom_range(0, 3))
               0:       row = POS_W'(band_lo);
               1:       row = POS_W'(band_lo - 1);
               2:       row = POS_W'(band_hi - 1);
               default: row = POS_W'(band_hi);
            endcase
         end else
            row = POS_W'($urandom_range(0, 2047));
         col  = POS_W'($urandom_range(0, 2047));
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            b = COLOR_W'($urandom_range(0, cur_bmax));
            g = COLOR_W'($urandom_range(cur_gmin, 255));
            r = COLOR_W'($urandom_range(cur_rmin, 255));
         end else if (pick < 75) begin
            b = COLOR_W'(cur_bmax + $urandom_range(0, 1));
            g = COLOR_W'(cur_gmin - $urandom_range(0, 1));
            r = COLOR_W'(cur_rmin - $urandom_range(0, 1));
         end else begin
            b = COLOR_W'($urandom);
            g = COLOR_W'($urandom);
            r = COLOR_W'($urandom);
         end
         send_px(b, g, r, col, row, i == n - 1);
      end
   endtask

   // Receiver flow control. It runs its own pattern of spans: always ready, ready at random,
   // or mostly stalled. When a long hold-off is asked for it holds rsp_tready low, so the
   // output register fills, the unit stops taking pixels and req_tready goes low while the
   // sender keeps offering.
   initial begin : rsp_flow
      int unsigned mode;
      int unsigned span;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done++;
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog: no correct run comes near this.
   initial begin : watchdog
      #50_000_000;
      $display("Timeout at %0t ns with %0d results still outstanding", $time, centroids_pending);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned rows, bmax, gmin, rmin;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_wen    <= 1'b0;
      csr_index  <= CSR_FRAME_ROWS;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames on the reset settings: 480 rows give a band of rows 288 to 335.
      // A lone non-matching pixel that ends the frame must give an all-zero result.
      send_px(8'd10, 8'd20, 8'd30, 11'd5, 11'd300, 1'b1);
      // Both band edges, the lower one with colors exactly on their limits, then one pixel just outside
      // each band edge and one just past each color limit, closed by a non-matching pixel.
      send_px(8'd200, 8'd170, 8'd170, 11'd2047, 11'd288, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd0, 11'd335, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd100, 11'd336, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd100, 11'd287, 1'b0);
      send_px(8'd201, 8'd255, 8'd255, 11'd7, 11'd300, 1'b0);
      send_px(8'd0, 8'd169, 8'd255, 11'd7, 11'd300, 1'b0);
      send_px(8'd0, 8'd255, 8'd169, 11'd7, 11'd300, 1'b0);
      send_px(8'd255, 8'd255, 8'd255, 11'd1024, 11'd310, 1'b1);

      // Zero frame rows leave the band empty even though every color passes.
      program_regs(0, 255, 0, 0);
      send_px(8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b1);

      // Frame rows past the row limit are clamped, so the band is rows 1228 to 1432, and
      // only pure marker color passes with the tightest limits.
      program_regs(4095, 0, 255, 255);
      send_px(8'd0, 8'd255, 8'd255, 11'd2047, 11'd1228, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd1, 11'd1432, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd5, 11'd1433, 1'b0);
      send_px(8'd1, 8'd255, 8'd255, 11'd5, 11'd1300, 1'b0);
      send_px(8'd0, 8'd254, 8'd255, 11'd5, 11'd1300, 1'b0);
      send_px(8'd0, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1);

      // Ten rows make a band of the single row 6.
      program_regs(10, 255, 0, 0);
      send_px(8'd255, 8'd0, 8'd0, 11'd3, 11'd6, 1'b0);
      send_px(8'd255, 8'd0, 8'd0, 11'd4, 11'd5, 1'b0);
      send_px(8'd255, 8'd0, 8'd0, 11'd9, 11'd7, 1'b1);

      // One row gives an empty band as well.
      program_regs(1, 255, 0, 0);
      send_px(8'd0, 8'd255, 8'd255, 11'd0, 11'd0, 1'b1);

      // Random phases, each on its own register setting. Every ninth phase starts a long
      // receiver hold-off and pushes many short frames into the stalled unit.
      phase = 0;
      while (pixels_sent < 20 + RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = 1;
            2:       rows = 10;
            3:       rows = MAX_ROWS;
            4:       rows = 4095;
            5:       rows = $urandom_range(MAX_ROWS + 1, 4095);
            6, 7:    rows = $urandom_range(2, 600);
            default: rows = $urandom_range(1, 2047);
         endcase
         bmax = ($urandom_range(0, 4) == 0) ? 0   : $urandom_range(0, 255);
         gmin = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
         rmin = ($urandom_range(0, 4) == 0) ? 0   : $urandom_range(0, 255);
         if ($urandom_range(0, 5) == 0) bmax = 255;
         if ($urandom_range(0, 5) == 0) gmin = 0;
         if ($urandom_range(0, 5) == 0) rmin = 255;
         program_regs(rows, bmax, gmin, rmin);
         sender_steady = ($urandom_range(0, 3) == 0);
         if (phase % 9 == 1) begin
            sender_steady = 1'b1;
            hold_asked <= hold_asked + 1;
            repeat (10) send_frame($urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(2, 6))
               send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(60, 160)
                                                      : $urandom_range(1, 30));
         end
         phase++;
      end

      // Let every result come home, then watch a while longer for stray results.
      drain_results();
      repeat (100) @(posedge clock);

      $display("Covered %0d pixels in %0d frames over %0d register settings.",
               pixels_sent, frames_sent, settings_used);
      $display("Compared %0d centroid results, %0d of them from frames with marker pixels.",
               centroids_checked, frames_with_hits);
      if (mismatches == 0 && centroids_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         if (centroids_pending != 0)
            $display("%0d frame results never arrived", centroids_pending);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
